// ===== src/rtme_pkg.sv =====
// Package for the receive token matching engine.
// Holds field widths, default sizes, result status codes and the control state type.
// Used by the interfaces, the search unit and the top level.
package rtme_pkg;
	localparam int GATES_DEF   = 8;
	localparam int ENTRIES_DEF = 16;

	localparam int GATE_W   = 3;
	localparam int PROTO_W  = 8;
	localparam int SEQ_W    = 16;
	localparam int HANDLE_W = 8;
	localparam int KEY_W    = PROTO_W + SEQ_W;
	localparam int REQ_W    = HANDLE_W + KEY_W;
	localparam int TOK_W    = KEY_W;

	typedef enum logic [1:0] {
		ST_STORED  = 2'd0,
		ST_MATCHED = 2'd1,
		ST_DROPPED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_PROC = 2'b10
	} ctrl_t;
endpackage

// ===== src/rtme_if.sv =====
// Handshake channels of the matching engine: input items and result items.
// Depends on rtme_pkg for the field widths.
interface rtme_in_if import rtme_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                mode;
	logic [GATE_W-1:0]   gate;
	logic [PROTO_W-1:0]  protocol;
	logic [SEQ_W-1:0]    sequence_req;
	logic [HANDLE_W-1:0] request_handle;
	modport source (output valid, mode, gate, protocol, sequence_req, request_handle,
		input ready);
	modport sink (input valid, mode, gate, protocol, sequence_req, request_handle,
		output ready);
endinterface

interface rtme_out_if import rtme_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic [HANDLE_W-1:0] released_handle;
	logic [GATE_W-1:0]   released_gate;
	modport source (output valid, status, released_handle, released_gate, input ready);
	modport sink (input valid, status, released_handle, released_gate, output ready);
endinterface

// ===== src/rtme_search.sv =====
// Searches one gate's ordered store row for the oldest entry with an equal key,
// and builds the row with that entry removed and later entries moved down.
// Depends on rtme_pkg for the key width.
module rtme_search import rtme_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int W       = REQ_W,
	parameter int CW      = $clog2(ENTRIES + 1)
) (
	input  logic [ENTRIES-1:0][W-1:0] row,
	input  logic [CW-1:0]             cnt,
	input  logic [KEY_W-1:0]          key,
	output logic                      hit,
	output logic [W-1:0]              hit_entry,
	output logic [ENTRIES-1:0][W-1:0] compact
);
	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] upto;

	always_comb begin
		for (int j = 0; j < ENTRIES; j++) begin
			match[j] = (CW'(j) < cnt) && (row[j][KEY_W-1:0] == key);
		end
		upto[0] = match[0];
		for (int j = 1; j < ENTRIES; j++) begin
			upto[j] = upto[j-1] | match[j];
		end
		hit = upto[ENTRIES-1];
		hit_entry = '0;
		for (int j = 0; j < ENTRIES; j++) begin
			if (match[j] && (j == 0 || !upto[(j > 0) ? j - 1 : 0])) begin
				hit_entry = hit_entry | row[j];
			end
		end
		// Every entry at or after the first hit takes its successor's place.
		for (int j = 0; j < ENTRIES; j++) begin
			if (upto[j] && j < ENTRIES - 1) begin
				compact[j] = row[(j < ENTRIES - 1) ? j + 1 : j];
			end else begin
				compact[j] = row[j];
			end
		end
	end
endmodule

// ===== src/receive_token_matching_engine.sv =====
// Top level of the receive token matching engine: control, row memories, result register.
// Depends on rtme_pkg, the channel interfaces and rtme_search.
//
//  channel | direction | contents
//  cmd     | in        | mode, gate, protocol, sequence_req, request_handle
//  rsp     | out       | status, released_handle, released_gate
//
// On acceptance in S_IDLE the gate's rows of both stores are read from their memories;
// in S_PROC they are searched, compacted or appended and written back. Reset clears
// per-gate valid bits, so no clearing pass is needed. A waiting result holds the
// item in S_PROC, and no new item is accepted until it leaves S_PROC.
module receive_token_matching_engine import rtme_pkg::*; #(
	parameter int GATES   = GATES_DEF,
	parameter int ENTRIES = ENTRIES_DEF
) (
	input logic     clk,
	input logic     arst_n,
	rtme_in_if.sink   cmd,
	rtme_out_if.source rsp
);
	localparam int AW = (GATES > 1) ? $clog2(GATES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int RROW_W = CW + ENTRIES * REQ_W;
	localparam int TROW_W = CW + ENTRIES * TOK_W;

	logic [RROW_W-1:0] req_mem [GATES];
	logic [TROW_W-1:0] tok_mem [GATES];
	logic [GATES-1:0]  rvld_q, tvld_q;

	ctrl_t state_q;
	logic [RROW_W-1:0] rrow_s1;
	logic [TROW_W-1:0] trow_s1;
	logic              rvld_s1, tvld_s1;

	logic                mode_q, ok_q;
	logic [AW-1:0]       addr_q;
	logic [GATE_W-1:0]   gate_q;
	logic [KEY_W-1:0]    key_q;
	logic [HANDLE_W-1:0] handle_q;

	logic                out_valid_q;
	status_t             status_q;
	logic [HANDLE_W-1:0] rel_handle_q;
	logic [GATE_W-1:0]   rel_gate_q;

	logic [6:0]    gate_ext;
	logic          gate_ok, accept, finish;
	logic [AW-1:0] addr;

	assign gate_ext = {4'b0, cmd.gate};
	assign gate_ok  = gate_ext < 7'(GATES);
	assign addr     = gate_ext[AW-1:0];
	assign cmd.ready = (state_q == S_IDLE);
	assign accept   = cmd.valid && cmd.ready;
	assign finish   = (state_q == S_PROC) && (!out_valid_q || rsp.ready);

	logic [ENTRIES-1:0][REQ_W-1:0] rrow, rcomp, rapp;
	logic [ENTRIES-1:0][TOK_W-1:0] trow, tcomp, tapp;
	logic [CW-1:0]     rcnt, tcnt;
	logic              rhit, thit;
	logic [REQ_W-1:0]  rhit_e;
	logic [TOK_W-1:0]  thit_e;

	assign rrow = rrow_s1[ENTRIES*REQ_W-1:0];
	assign trow = trow_s1[ENTRIES*TOK_W-1:0];
	assign rcnt = rvld_s1 ? rrow_s1[RROW_W-1 -: CW] : '0;
	assign tcnt = tvld_s1 ? trow_s1[TROW_W-1 -: CW] : '0;

	rtme_search #(.ENTRIES(ENTRIES), .W(REQ_W), .CW(CW)) u_req_search (
		.row(rrow), .cnt(rcnt), .key(key_q), .hit(rhit), .hit_entry(rhit_e), .compact(rcomp)
	);
	rtme_search #(.ENTRIES(ENTRIES), .W(TOK_W), .CW(CW)) u_tok_search (
		.row(trow), .cnt(tcnt), .key(key_q), .hit(thit), .hit_entry(thit_e), .compact(tcomp)
	);

	always_comb begin
		for (int j = 0; j < ENTRIES; j++) begin
			rapp[j] = (CW'(j) == rcnt) ? {handle_q, key_q} : rrow[j];
			tapp[j] = (CW'(j) == tcnt) ? key_q : trow[j];
		end
	end

	// Result and write-back decisions for the item in S_PROC.
	status_t             nx_status;
	logic [HANDLE_W-1:0] nx_handle;
	logic [GATE_W-1:0]   nx_gate;
	logic                rwr, twr;
	logic [RROW_W-1:0]   rwdata;
	logic [TROW_W-1:0]   twdata;

	always_comb begin
		nx_status = ST_DROPPED;
		nx_handle = '0;
		nx_gate   = '0;
		rwr = 1'b0;
		twr = 1'b0;
		rwdata = {rcnt, rapp};
		twdata = {tcnt, tapp};
		if (ok_q) begin
			if (!mode_q) begin
				if (thit) begin
					nx_status = ST_MATCHED;
					nx_handle = handle_q;
					nx_gate   = gate_q;
					twr = 1'b1;
					twdata = {tcnt - CW'(1), tcomp};
				end else if (rcnt != CW'(ENTRIES)) begin
					nx_status = ST_STORED;
					rwr = 1'b1;
					rwdata = {rcnt + CW'(1), rapp};
				end
			end else begin
				if (rhit) begin
					nx_status = ST_MATCHED;
					nx_handle = rhit_e[REQ_W-1 -: HANDLE_W];
					nx_gate   = gate_q;
					rwr = 1'b1;
					rwdata = {rcnt - CW'(1), rcomp};
				end else if (tcnt != CW'(ENTRIES)) begin
					nx_status = ST_STORED;
					twr = 1'b1;
					twdata = {tcnt + CW'(1), tapp};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && gate_ok) begin
			rrow_s1 <= req_mem[addr];
			trow_s1 <= tok_mem[addr];
		end
		if (finish && rwr) begin
			req_mem[addr_q] <= rwdata;
		end
		if (finish && twr) begin
			tok_mem[addr_q] <= twdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= cmd.mode;
			ok_q     <= gate_ok;
			addr_q   <= addr;
			gate_q   <= cmd.gate;
			key_q    <= {cmd.protocol, cmd.sequence_req};
			handle_q <= cmd.request_handle;
			rvld_s1  <= gate_ok && rvld_q[addr];
			tvld_s1  <= gate_ok && tvld_q[addr];
		end
		if (finish) begin
			status_q     <= nx_status;
			rel_handle_q <= nx_handle;
			rel_gate_q   <= nx_gate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			rvld_q      <= '0;
			tvld_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_PROC;
					end
				end
				S_PROC: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (finish) begin
				out_valid_q <= 1'b1;
				if (rwr) begin
					rvld_q[addr_q] <= 1'b1;
				end
				if (twr) begin
					tvld_q[addr_q] <= 1'b1;
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = status_q;
	assign rsp.released_handle = rel_handle_q;
	assign rsp.released_gate   = rel_gate_q;
endmodule

// ===== tb/receive_token_matching_engine_tb.sv =====
// Self-checking testbench for the receive token matching engine.
// Depends on rtme_pkg, the channel interfaces and the top level of the block.
// A local model of both per-gate stores predicts each result; a monitor compares them.
module receive_token_matching_engine_tb;
	import rtme_pkg::*;

	localparam int NGATE = GATES_DEF;
	localparam int DEPTH = ENTRIES_DEF;

	typedef struct packed {
		logic [1:0]          status;
		logic [HANDLE_W-1:0] handle;
		logic [GATE_W-1:0]   gate;
	} outcome_t;

	typedef struct packed {
		logic [PROTO_W-1:0]  protocol;
		logic [SEQ_W-1:0]    seq;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	logic clk;
	logic arst_n;
	rtme_in_if  cmd ();
	rtme_out_if rsp ();

	receive_token_matching_engine i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.rsp   (rsp)
	);

	entry_t   pending_reqs [NGATE][$];
	entry_t   early_tokens [NGATE][$];
	outcome_t expected_outcomes [$];
	int       errors;
	int       results_seen;
	int       matches_seen;
	int       drops_seen;
	int       burst_left;
	int       stall_phase;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Pairs a request or token with the oldest equal-key opposite entry of its gate, else stores or drops it.
	function automatic outcome_t predict_match(logic m, logic [GATE_W-1:0] g,
			logic [PROTO_W-1:0] p, logic [SEQ_W-1:0] s, logic [HANDLE_W-1:0] h);
		outcome_t o;
		entry_t   e;
		o = '{status: ST_DROPPED, handle: '0, gate: '0};
		if (int'(g) >= NGATE)
			return o;
		e = '{protocol: p, seq: s, handle: h};
		if (m == 1'b0) begin
			for (int i = 0; i < early_tokens[g].size(); i++) begin
				if (early_tokens[g][i].protocol == p && early_tokens[g][i].seq == s) begin
					early_tokens[g].delete(i);
					return '{status: ST_MATCHED, handle: h, gate: g};
				end
			end
			if (pending_reqs[g].size() >= DEPTH)
				return o;
			pending_reqs[g].push_back(e);
		end else begin
			for (int i = 0; i < pending_reqs[g].size(); i++) begin
				if (pending_reqs[g][i].protocol == p && pending_reqs[g][i].seq == s) begin
					o = '{status: ST_MATCHED, handle: pending_reqs[g][i].handle, gate: g};
					pending_reqs[g].delete(i);
					return o;
				end
			end
			if (early_tokens[g].size() >= DEPTH)
				return o;
			e.handle = '0;
			early_tokens[g].push_back(e);
		end
		return '{status: ST_STORED, handle: '0, gate: '0};
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("error at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
		errors++;
	endtask

	// Sends one item; bursts of random length are separated by random gaps.
	// Valid stays high between items of a burst, since the block is not ready then.
	task automatic send_item(logic m, logic [GATE_W-1:0] g, logic [PROTO_W-1:0] p,
			logic [SEQ_W-1:0] s, logic [HANDLE_W-1:0] h);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				cmd.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		cmd.valid          <= 1'b1;
		cmd.mode           <= m;
		cmd.gate           <= g;
		cmd.protocol       <= p;
		cmd.sequence_req   <= s;
		cmd.request_handle <= h;
		do @(posedge clk); while (!cmd.ready);
		expected_outcomes.push_back(predict_match(m, g, p, s, h));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		cmd.valid <= 1'b0;
		while (expected_outcomes.size() != 0)
			@(negedge clk);
	endtask

	// Receiver stalls in a rotating pattern: free running, light, then heavy back-pressure.
	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		case ((stall_phase >> 7) % 3)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= ($urandom_range(0, 3) != 0);
			default: rsp.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_outcomes.size() == 0) begin
				report_mismatch("unexpected result, status", rsp.status, -1);
			end else begin
				want = expected_outcomes.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
				if (rsp.released_handle !== want.handle)
					report_mismatch("released_handle", rsp.released_handle, want.handle);
				if (rsp.released_gate !== want.gate)
					report_mismatch("released_gate", rsp.released_gate, want.gate);
				if (want.status == ST_MATCHED)
					matches_seen++;
				if (want.status == ST_DROPPED)
					drops_seen++;
			end
			results_seen++;
		end
	end

	// Fills one gate's request store past full, hits it, then does the same for tokens.
	task automatic test_full_stores();
		for (int i = 0; i <= DEPTH; i++)
			send_item(1'b0, 3'd7, 8'hFF, 16'(i), 8'(i + 200));
		send_item(1'b1, 3'd7, 8'hFF, 16'd5, 8'hAA);
		send_item(1'b1, 3'd7, 8'hFF, 16'd0, 8'h00);
		for (int i = 0; i <= DEPTH; i++)
			send_item(1'b1, 3'd0, 8'h00, 16'hFFFF, 8'h55);
		send_item(1'b0, 3'd0, 8'h00, 16'hFFFF, 8'hFF);
	endtask

	task automatic test_directed();
		send_item(1'b1, 3'd3, 8'h12, 16'h8000, 8'hFF);
		send_item(1'b0, 3'd3, 8'h12, 16'h8000, 8'h00);
		send_item(1'b0, 3'd4, 8'hAB, 16'h0001, 8'h11);
		send_item(1'b0, 3'd4, 8'hAB, 16'h0001, 8'h22);
		send_item(1'b1, 3'd5, 8'hAB, 16'h0001, 8'h33);
		send_item(1'b1, 3'd4, 8'hAB, 16'h0001, 8'h44);
		send_item(1'b1, 3'd4, 8'hAB, 16'h0001, 8'h00);
		wait_drained();
	endtask

	// Small keys on few gates so that requests and tokens meet often.
	task automatic test_random(int n);
		logic [GATE_W-1:0] g;
		for (int i = 0; i < n; i++) begin
			g = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 2)) : 3'($urandom);
			if ($urandom_range(0, 9) < 8)
				send_item(1'($urandom), g, 8'($urandom_range(0, 3)) ^ {8{i[9]}},
					16'($urandom_range(0, 5)) ^ {16{i[8]}}, 8'($urandom));
			else
				send_item(1'($urandom), g, 8'($urandom), 16'($urandom), 8'($urandom));
			if (i == n / 2)
				wait_drained();
		end
	endtask

	initial begin
		errors       = 0;
		results_seen = 0;
		matches_seen = 0;
		drops_seen   = 0;
		burst_left   = 0;
		stall_phase  = 0;
		arst_n       = 1'b0;
		cmd.valid          = 1'b0;
		cmd.mode           = 1'b0;
		cmd.gate           = '0;
		cmd.protocol       = '0;
		cmd.sequence_req   = '0;
		cmd.request_handle = '0;
		rsp.ready          = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_full_stores();
		test_directed();
		test_random(1500);
		wait_drained();
		repeat (20) @(negedge clk);
		$display("covered %0d results: %0d matched, %0d dropped on full stores",
			results_seen, matches_seen, drops_seen);
		if (errors == 0 && expected_outcomes.size() == 0)
			$display("receive_token_matching_engine: match");
		else
			$display("receive_token_matching_engine: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("receive_token_matching_engine: mismatch");
		$finish;
	end
endmodule

// ===== sim.f =====
src/rtme_pkg.sv
src/rtme_if.sv
src/rtme_search.sv
src/receive_token_matching_engine.sv
tb/receive_token_matching_engine_tb.sv
